// File: rtl/qslerp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and the CORDIC arctangent table for the quaternion
// slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam logic [14:0] THR_RESET = 15'd16;
    localparam logic [16:0] ONE_T     = 17'd65536;

    // Input beat: two Q1.15 quaternions and a Q1.16 weight
    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic        [16:0] weight;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
        logic               used_linear;
    } out_beat_t;

    // Per-item context carried alongside the arithmetic units
    typedef struct packed {
        logic [3:0][16:0] qa;      // first quaternion, sign-adjusted, 17 bits
        logic [3:0][15:0] qb;      // second quaternion
        logic [16:0]      t;       // saturated weight
        logic             linear;  // linear blend selected
    } ctx_t;

    // atan(2^-i) in Q30
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
    };

    // Step angle rounded half up from Q30 to Q frac
    function automatic logic [31:0] step_angle(input int i, input int frac);
        logic [31:0] v;
        int          s;
        v = {2'b00, ATAN_Q30[i[4:0]]};
        s = 30 - frac;
        if (s == 0) begin
            return v;
        end
        return (v + (32'd1 << (s - 1))) >> s;
    endfunction

endpackage

// File: rtl/qslerp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qslerp_isqrt
    import qslerp_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2*FRAC_BITS:0] in_n,
    input  logic [FRAC_BITS:0]   in_d,
    input  ctx_t                 in_ctx,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS:0]   out_root,
    output logic [FRAC_BITS:0]   out_d,
    output ctx_t                 out_ctx
);

    localparam int NS  = FRAC_BITS + 1;
    localparam int NW  = 2 * FRAC_BITS + 2;
    localparam int RMW = FRAC_BITS + 4;

    logic [NS-1:0]      vld_reg;
    logic [NS:0]        adv;
    logic [NW-1:0]      n_reg    [NS];
    logic [RMW-1:0]     rem_reg  [NS];
    logic [NS-1:0]      root_reg [NS];
    logic [FRAC_BITS:0] d_reg    [NS];
    ctx_t               ctx_reg  [NS];

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_d     = d_reg[NS-1];
    assign out_ctx   = ctx_reg[NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [NW-1:0]      n_in;
        logic [RMW-1:0]     rem_in;
        logic [NS-1:0]      root_in;
        logic [FRAC_BITS:0] d_in;
        ctx_t               ctx_in;
        logic               v_in;
        logic [RMW-1:0]     rem_sh;
        logic [RMW-1:0]     trial;
        logic [RMW-1:0]     rem_next;
        logic [NS-1:0]      root_next;

        assign adv[k] = ~vld_reg[k] | adv[k+1];

        if (k == 0) begin : g_first
            assign n_in    = {1'b0, in_n};
            assign rem_in  = '0;
            assign root_in = '0;
            assign d_in    = in_d;
            assign ctx_in  = in_ctx;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign d_in    = d_reg[k-1];
            assign ctx_in  = ctx_reg[k-1];
            assign v_in    = vld_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[RMW-3:0], n_in[NW-1:NW-2]};
            trial  = RMW'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[NS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                n_reg[k]    <= n_in << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                d_reg[k]    <= d_in;
                ctx_reg[k]  <= ctx_in;
            end
        end
    end

endmodule

// File: rtl/qslerp_cordic_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_vec
// Vectoring CORDIC, one micro-rotation per stage: angle of (x, y).
// ----------------------------------------------------------------------------
module qslerp_cordic_vec
    import qslerp_pkg::*;
#(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [FRAC_BITS:0]          in_x,
    input  logic [FRAC_BITS:0]          in_y,
    input  ctx_t                        in_ctx,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FRAC_BITS+2:0] out_angle,
    output ctx_t                        out_ctx
);

    localparam int NS = CORDIC_STEPS;
    localparam int SW = FRAC_BITS + 3;

    logic [NS-1:0]        vld_reg;
    logic [NS:0]          adv;
    logic signed [SW-1:0] x_reg   [NS];
    logic signed [SW-1:0] y_reg   [NS];
    logic signed [SW-1:0] z_reg   [NS];
    ctx_t                 ctx_reg [NS];

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_angle = z_reg[NS-1];
    assign out_ctx   = ctx_reg[NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic signed [SW-1:0] ANG = SW'(step_angle(k, FRAC_BITS));
        logic signed [SW-1:0] x_in;
        logic signed [SW-1:0] y_in;
        logic signed [SW-1:0] z_in;
        ctx_t                 ctx_in;
        logic                 v_in;
        logic signed [SW-1:0] dx;
        logic signed [SW-1:0] dy;

        assign adv[k] = ~vld_reg[k] | adv[k+1];

        if (k == 0) begin : g_first
            assign x_in   = SW'(in_x);
            assign y_in   = SW'(in_y);
            assign z_in   = '0;
            assign ctx_in = in_ctx;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign x_in   = x_reg[k-1];
            assign y_in   = y_reg[k-1];
            assign z_in   = z_reg[k-1];
            assign ctx_in = ctx_reg[k-1];
            assign v_in   = vld_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                // rotate toward the x axis
                if (!y_in[SW-1]) begin
                    x_reg[k] <= x_in + dx;
                    y_reg[k] <= y_in - dy;
                    z_reg[k] <= z_in + ANG;
                end else begin
                    x_reg[k] <= x_in - dx;
                    y_reg[k] <= y_in + dy;
                    z_reg[k] <= z_in - ANG;
                end
                ctx_reg[k] <= ctx_in;
            end
        end
    end

endmodule

// File: rtl/qslerp_cordic_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_rot
// Three-lane rotation CORDIC giving the (gain-scaled) sine of each angle.
// ----------------------------------------------------------------------------
module qslerp_cordic_rot
    import qslerp_pkg::*;
#(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [FRAC_BITS+2:0] in_angle [3],
    input  ctx_t                        in_ctx,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FRAC_BITS+2:0] out_sine [3],
    output ctx_t                        out_ctx
);

    localparam int NS = CORDIC_STEPS;
    localparam int SW = FRAC_BITS + 3;
    localparam logic signed [SW-1:0] X_INIT = SW'(1) << FRAC_BITS;

    logic [NS-1:0]        vld_reg;
    logic [NS:0]          adv;
    logic signed [SW-1:0] x_reg   [NS][3];
    logic signed [SW-1:0] y_reg   [NS][3];
    logic signed [SW-1:0] z_reg   [NS][3];
    ctx_t                 ctx_reg [NS];

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_ctx   = ctx_reg[NS-1];
    assign out_sine  = y_reg[NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic signed [SW-1:0] ANG = SW'(step_angle(k, FRAC_BITS));
        logic signed [SW-1:0] x_in [3];
        logic signed [SW-1:0] y_in [3];
        logic signed [SW-1:0] z_in [3];
        ctx_t                 ctx_in;
        logic                 v_in;

        assign adv[k] = ~vld_reg[k] | adv[k+1];

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    x_in[l] = X_INIT;
                    y_in[l] = '0;
                    z_in[l] = in_angle[l];
                end
            end
            assign ctx_in = in_ctx;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign x_in   = x_reg[k-1];
            assign y_in   = y_reg[k-1];
            assign z_in   = z_reg[k-1];
            assign ctx_in = ctx_reg[k-1];
            assign v_in   = vld_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                for (int l = 0; l < 3; l++) begin
                    // drive the residual angle toward zero
                    if (!z_in[l][SW-1]) begin
                        x_reg[k][l] <= x_in[l] - (y_in[l] >>> k);
                        y_reg[k][l] <= y_in[l] + (x_in[l] >>> k);
                        z_reg[k][l] <= z_in[l] - ANG;
                    end else begin
                        x_reg[k][l] <= x_in[l] + (y_in[l] >>> k);
                        y_reg[k][l] <= y_in[l] - (x_in[l] >>> k);
                        z_reg[k][l] <= z_in[l] + ANG;
                    end
                end
                ctx_reg[k] <= ctx_in;
            end
        end
    end

endmodule

// File: rtl/qslerp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_div
// Two-lane pipelined restoring divider for the slerp weights:
// w = clamp(num * 2^F / den, 0, one), one quotient bit per stage.
// ----------------------------------------------------------------------------
module qslerp_div
    import qslerp_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [FRAC_BITS+2:0] in_num [2],
    input  logic signed [FRAC_BITS+2:0] in_den,
    input  ctx_t                        in_ctx,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [FRAC_BITS:0]          out_w [2],
    output ctx_t                        out_ctx
);

    localparam int NS = FRAC_BITS + 2;
    localparam int SW = FRAC_BITS + 3;
    localparam int RW = 2 * FRAC_BITS + 4;
    localparam int UW = SW - 1;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [NS-1:0]  vld_reg;
    logic [NS:0]    adv;
    logic [RW-1:0]  rem_reg  [NS][2];
    logic [NS-1:0]  q_reg    [NS][2];
    logic [1:0]     zero_reg [NS];
    logic [1:0]     over_reg [NS];
    logic [UW-1:0]  den_reg  [NS];
    ctx_t           ctx_reg  [NS];

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_ctx   = ctx_reg[NS-1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (zero_reg[NS-1][l]) begin
                out_w[l] = '0;
            end else if (over_reg[NS-1][l] || q_reg[NS-1][l] > NS'(ONE)) begin
                out_w[l] = ONE;
            end else begin
                out_w[l] = q_reg[NS-1][l][FRAC_BITS:0];
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [RW-1:0] rem_in [2];
        logic [NS-1:0] q_in   [2];
        logic [1:0]    zero_in;
        logic [1:0]    over_in;
        logic [UW-1:0] den_in;
        ctx_t          ctx_in;
        logic          v_in;
        logic [RW-1:0] dsh;

        assign adv[k] = ~vld_reg[k] | adv[k+1];

        if (k == 0) begin : g_first
            always_comb begin
                den_in = in_den[UW-1:0];
                for (int l = 0; l < 2; l++) begin
                    // non-positive numerator gives a zero weight
                    zero_in[l] = in_num[l][SW-1] || (in_num[l] == '0);
                    // quotient beyond the stage count saturates
                    over_in[l] = (UW+2)'(in_num[l][UW-1:0]) >= ((UW+2)'(den_in) << 2);
                    rem_in[l]  = RW'(in_num[l][UW-1:0]) << FRAC_BITS;
                    q_in[l]    = '0;
                end
            end
            assign ctx_in = in_ctx;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign zero_in = zero_reg[k-1];
            assign over_in = over_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign ctx_in  = ctx_reg[k-1];
            assign v_in    = vld_reg[k-1];
        end

        assign dsh = RW'(den_in) << (NS - 1 - k);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                for (int l = 0; l < 2; l++) begin
                    if (rem_in[l] >= dsh) begin
                        rem_reg[k][l] <= rem_in[l] - dsh;
                        q_reg[k][l]   <= q_in[l] | (NS'(1) << (NS - 1 - k));
                    end else begin
                        rem_reg[k][l] <= rem_in[l];
                        q_reg[k][l]   <= q_in[l];
                    end
                end
                zero_reg[k] <= zero_in;
                over_reg[k] <= over_in;
                den_reg[k]  <= den_in;
                ctx_reg[k]  <= ctx_in;
            end
        end
    end

endmodule

// File: rtl/quaternion_slerp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp_unit
// Fixed-point quaternion slerp with a linear-blend fallback near parallel.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one beat of two Q1.15 quaternions and a
//   Q1.16 weight. m_valid/m_ready/m_data return the Q1.15 result, saturated,
//   with used_linear set when the linear blend was taken.
//   cfg_wr_en/cfg_wr_data write the near-parallel margin (reset 16); write it
//   only while the pipeline is empty.
//   The pipeline is five dot/setup stages, FRAC_BITS+1 square-root stages,
//   CORDIC_STEPS vectoring stages, two angle stages, CORDIC_STEPS rotation
//   stages, FRAC_BITS+2 divider stages and three blend stages.
//   Throughput is one beat per cycle; every stage holds its own valid bit.
//   When m_ready is low the result register holds, and each stage advances
//   only into an empty slot, so beats keep entering until the pipe is full.
//   Reset clears all valid bits and loads the margin register.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit
    import qslerp_pkg::*;
#(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data
);

    localparam int F   = FRAC_BITS;
    localparam int DW  = F + 1;
    localparam int NW  = 2 * F + 1;
    localparam int SW  = F + 3;
    localparam int TW  = F + 2;
    localparam int PRW = TW + 17;
    localparam int WW  = (F + 1 > 17) ? F + 1 : 17;
    localparam int PW  = WW + 18;
    localparam int RSH = 30 - F;
    localparam logic [DW-1:0]   ONE    = DW'(1) << F;
    localparam logic [2*DW-1:0] ONE_SQ = (2*DW)'(1) << (2 * F);
    localparam logic [34:0]     HALF_D = (35'(1) << RSH) >> 1;

    logic [14:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // ---------------- front: dot product and setup ----------------
    logic [4:0]          fv_reg;
    logic [5:0]          f_adv;
    logic signed [31:0]  p1_reg [4];
    ctx_t                ctx1_reg;
    logic signed [33:0]  dot2_reg;
    ctx_t                ctx2_reg;
    logic [DW-1:0]       d3_reg;
    ctx_t                ctx3_reg;
    logic [2*DW-1:0]     dsq4_reg;
    logic [DW-1:0]       d4_reg;
    ctx_t                ctx4_reg;
    logic [NW-1:0]       n5_reg;
    logic [DW-1:0]       d5_reg;
    ctx_t                ctx5_reg;

    logic                isq_ready;
    ctx_t                ctx1_next;
    ctx_t                ctx3_next;
    logic signed [33:0]  dot2_next;
    logic [33:0]         dabs;
    logic [33:0]         lin_lim;
    logic [34:0]         d_full;
    logic [DW-1:0]       d3_next;

    assign s_ready  = f_adv[0];
    assign f_adv[5] = isq_ready;

    for (genvar k = 0; k < 5; k++) begin : g_fadv
        assign f_adv[k] = ~fv_reg[k] | f_adv[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else begin
            if (f_adv[0]) fv_reg[0] <= s_valid;
            for (int k = 1; k < 5; k++) begin
                if (f_adv[k]) fv_reg[k] <= fv_reg[k-1];
            end
        end
    end

    always_comb begin
        ctx1_next.qa[0] = 17'(s_data.a_x);
        ctx1_next.qa[1] = 17'(s_data.a_y);
        ctx1_next.qa[2] = 17'(s_data.a_z);
        ctx1_next.qa[3] = 17'(s_data.a_w);
        ctx1_next.qb[0] = s_data.b_x;
        ctx1_next.qb[1] = s_data.b_y;
        ctx1_next.qb[2] = s_data.b_z;
        ctx1_next.qb[3] = s_data.b_w;
        ctx1_next.t     = (s_data.weight > ONE_T) ? ONE_T : s_data.weight;
        ctx1_next.linear = 1'b0;
    end

    assign dot2_next = 34'(p1_reg[0]) + 34'(p1_reg[1]) + 34'(p1_reg[2]) + 34'(p1_reg[3]);

    always_comb begin
        dabs    = dot2_reg[33] ? 34'(-dot2_reg) : 34'(dot2_reg);
        lin_lim = 34'(16'd32768 - {1'b0, thr_reg}) << 15;
        d_full  = (35'(dabs) + HALF_D) >> RSH;
        d3_next = (d_full > 35'(ONE)) ? ONE : d_full[DW-1:0];
        ctx3_next = ctx2_reg;
        ctx3_next.linear = dabs >= lin_lim;
        for (int k = 0; k < 4; k++) begin
            // take the short arc: flip the first quaternion
            if (dot2_reg[33]) ctx3_next.qa[k] = 17'(-$signed(ctx2_reg.qa[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (f_adv[0]) begin
            p1_reg[0] <= s_data.a_x * s_data.b_x;
            p1_reg[1] <= s_data.a_y * s_data.b_y;
            p1_reg[2] <= s_data.a_z * s_data.b_z;
            p1_reg[3] <= s_data.a_w * s_data.b_w;
            ctx1_reg  <= ctx1_next;
        end
        if (f_adv[1]) begin
            dot2_reg <= dot2_next;
            ctx2_reg <= ctx1_reg;
        end
        if (f_adv[2]) begin
            d3_reg   <= d3_next;
            ctx3_reg <= ctx3_next;
        end
        if (f_adv[3]) begin
            dsq4_reg <= d3_reg * d3_reg;
            d4_reg   <= d3_reg;
            ctx4_reg <= ctx3_reg;
        end
        if (f_adv[4]) begin
            n5_reg   <= NW'(ONE_SQ - dsq4_reg);
            d5_reg   <= d4_reg;
            ctx5_reg <= ctx4_reg;
        end
    end

    // ---------------- sqrt(1 - d^2) and theta ----------------
    logic          isq_valid;
    logic          vec_ready;
    logic [DW-1:0] isq_root;
    logic [DW-1:0] isq_d;
    ctx_t          isq_ctx;

    qslerp_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fv_reg[4]),
        .in_ready  (isq_ready),
        .in_n      (n5_reg),
        .in_d      (d5_reg),
        .in_ctx    (ctx5_reg),
        .out_valid (isq_valid),
        .out_ready (vec_ready),
        .out_root  (isq_root),
        .out_d     (isq_d),
        .out_ctx   (isq_ctx)
    );

    logic                 vec_valid;
    logic                 mv_ready;
    logic signed [SW-1:0] vec_angle;
    ctx_t                 vec_ctx;

    qslerp_cordic_vec #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (isq_valid),
        .in_ready  (vec_ready),
        .in_x      (isq_d),
        .in_y      (isq_root),
        .in_ctx    (isq_ctx),
        .out_valid (vec_valid),
        .out_ready (mv_ready),
        .out_angle (vec_angle),
        .out_ctx   (vec_ctx)
    );

    // ---------------- angle split ----------------
    logic [1:0]     mv_reg;
    logic [2:0]     m_adv;
    logic [TW-1:0]  th1_reg;
    logic [PRW-1:0] prod1_reg;
    ctx_t           mctx1_reg;
    logic [TW-1:0]  th2_reg;
    logic [TW-1:0]  phi0_reg;
    logic [TW-1:0]  phi1_reg;
    ctx_t           mctx2_reg;
    logic           rot_ready;
    logic [TW-1:0]  th1_next;
    logic [PRW:0]   phi_sum;
    logic [TW-1:0]  phi1_next;

    assign mv_ready = m_adv[0];
    assign m_adv[2] = rot_ready;
    assign m_adv[1] = ~mv_reg[1] | m_adv[2];
    assign m_adv[0] = ~mv_reg[0] | m_adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= '0;
        end else begin
            if (m_adv[0]) mv_reg[0] <= vec_valid;
            if (m_adv[1]) mv_reg[1] <= mv_reg[0];
        end
    end

    assign th1_next  = vec_angle[SW-1] ? '0 : vec_angle[TW-1:0];
    assign phi_sum   = (PRW+1)'(prod1_reg) + (PRW+1)'(32768);
    assign phi1_next = phi_sum[TW+15:16];

    always_ff @(posedge aclk) begin
        if (m_adv[0]) begin
            th1_reg   <= th1_next;
            prod1_reg <= PRW'(vec_ctx.t) * PRW'(th1_next);
            mctx1_reg <= vec_ctx;
        end
        if (m_adv[1]) begin
            th2_reg   <= th1_reg;
            phi1_reg  <= phi1_next;
            phi0_reg  <= th1_reg - phi1_next;
            mctx2_reg <= mctx1_reg;
        end
    end

    // ---------------- sines and weights ----------------
    logic signed [SW-1:0] rot_angle [3];
    logic signed [SW-1:0] rot_sine  [3];
    logic                 rot_valid;
    logic                 div_ready;
    ctx_t                 rot_ctx;

    assign rot_angle[0] = SW'(th2_reg);
    assign rot_angle[1] = SW'(phi0_reg);
    assign rot_angle[2] = SW'(phi1_reg);

    qslerp_cordic_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mv_reg[1]),
        .in_ready  (rot_ready),
        .in_angle  (rot_angle),
        .in_ctx    (mctx2_reg),
        .out_valid (rot_valid),
        .out_ready (div_ready),
        .out_sine  (rot_sine),
        .out_ctx   (rot_ctx)
    );

    logic signed [SW-1:0] div_num [2];
    ctx_t                 div_ctx_in;
    logic                 div_valid;
    logic                 bk_ready;
    logic [DW-1:0]        div_w [2];
    ctx_t                 div_ctx;

    assign div_num[0] = rot_sine[1];
    assign div_num[1] = rot_sine[2];

    always_comb begin
        div_ctx_in = rot_ctx;
        // a non-positive sin(theta) falls back to the linear blend
        div_ctx_in.linear = rot_ctx.linear || rot_sine[0][SW-1] || (rot_sine[0] == '0);
    end

    qslerp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (div_ready),
        .in_num    (div_num),
        .in_den    (rot_sine[0]),
        .in_ctx    (div_ctx_in),
        .out_valid (div_valid),
        .out_ready (bk_ready),
        .out_w     (div_w),
        .out_ctx   (div_ctx)
    );

    // ---------------- blend ----------------
    logic [2:0]           bv_reg;
    logic [3:0]           b_adv;
    logic [WW-1:0]        b1_wa_reg;
    logic [WW-1:0]        b1_wb_reg;
    logic                 b1_lin_reg;
    logic [3:0][16:0]     b1_qa_reg;
    logic [3:0][15:0]     b1_qb_reg;
    logic signed [PW-1:0] b2_pa_reg [4];
    logic signed [PW-1:0] b2_pb_reg [4];
    logic                 b2_lin_reg;
    out_beat_t            out_reg;
    logic signed [15:0]   res_next [4];

    assign bk_ready = b_adv[0];
    assign b_adv[3] = m_ready;
    for (genvar k = 0; k < 3; k++) begin : g_badv
        assign b_adv[k] = ~bv_reg[k] | b_adv[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else begin
            if (b_adv[0]) bv_reg[0] <= div_valid;
            if (b_adv[1]) bv_reg[1] <= bv_reg[0];
            if (b_adv[2]) bv_reg[2] <= bv_reg[1];
        end
    end

    function automatic logic signed [15:0] sat16(input logic signed [PW:0] v);
        if (v > (PW+1)'(32767)) return 16'sd32767;
        if (v < -(PW+1)'(32768)) return -16'sd32768;
        return v[15:0];
    endfunction

    always_comb begin
        logic signed [PW:0] acc;
        for (int k = 0; k < 4; k++) begin
            acc = (PW+1)'(b2_pa_reg[k]) + (PW+1)'(b2_pb_reg[k]);
            if (b2_lin_reg) begin
                acc = (acc + (PW+1)'(32768)) >>> 16;
            end else begin
                acc = (acc + $signed((PW+1)'(ONE >> 1))) >>> F;
            end
            res_next[k] = sat16(acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv[0]) begin
            if (div_ctx.linear) begin
                b1_wa_reg <= WW'(ONE_T - div_ctx.t);
                b1_wb_reg <= WW'(div_ctx.t);
            end else begin
                b1_wa_reg <= WW'(div_w[0]);
                b1_wb_reg <= WW'(div_w[1]);
            end
            b1_lin_reg <= div_ctx.linear;
            b1_qa_reg  <= div_ctx.qa;
            b1_qb_reg  <= div_ctx.qb;
        end
        if (b_adv[1]) begin
            for (int k = 0; k < 4; k++) begin
                b2_pa_reg[k] <= $signed({1'b0, b1_wa_reg}) * $signed(b1_qa_reg[k]);
                b2_pb_reg[k] <= $signed({1'b0, b1_wb_reg}) * $signed(b1_qb_reg[k]);
            end
            b2_lin_reg <= b1_lin_reg;
        end
        if (b_adv[2]) begin
            out_reg.out_x       <= res_next[0];
            out_reg.out_y       <= res_next[1];
            out_reg.out_z       <= res_next[2];
            out_reg.out_w       <= res_next[3];
            out_reg.used_linear <= b2_lin_reg;
        end
    end

    assign m_valid = bv_reg[2];
    assign m_data  = out_reg;

    // ---------------- checks ----------------
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> fv_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> fv_reg[0])
        else $error("input stalled with an empty first stage");

    a_weight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bv_reg[0] && !b1_lin_reg |-> (b1_wa_reg <= WW'(ONE)) && (b1_wb_reg <= WW'(ONE)))
        else $error("slerp weight above one");

endmodule

// File: tb/sv/tb_quaternion_slerp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_unit
// Streams quaternion pairs through the slerp pipeline under random bursts,
// gaps and output stalls, and checks every result beat against a bit-exact
// fixed-point model of the dot, CORDIC, divide and blend arithmetic.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_unit;
    import qslerp_pkg::*;

    localparam int FRAC  = 15;
    localparam int STEPS = 16;
    localparam int LATENCY = 2 * FRAC + 2 * STEPS + 13;
    localparam int NUM_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [14:0] THR_MAX = 15'h7fff;
    localparam logic [14:0] THR_MIN = 15'd0;

    // arithmetic shift right with floor semantics
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint step_atan(int i);
        longint v;
        v = longint'(ATAN_Q30[i]);
        return (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += step_atan(i);
            end else begin
                x -= dx; y += dy; z -= step_atan(i);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x, y, dx, dy;
        x = 64'sd1 <<< FRAC;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= step_atan(i);
            end else begin
                x += dx; y -= dy; z += step_atan(i);
            end
        end
        return y;
    endfunction

    function automatic longint blend_weight(longint num, longint den);
        longint one, r;
        one = 64'sd1 <<< FRAC;
        r = (num * one) / den;  // truncates toward zero
        if (r < 0) return 0;
        if (r > one) return one;
        return r;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    function automatic out_beat_t slerp_result(in_beat_t d, logic [14:0] thr);
        longint a[4], b[4], dot, t, one, dq, s, theta, phi0, phi1, sth, w0, w1;
        logic lin;
        logic signed [15:0] r[4];
        out_beat_t o;
        one = 64'sd1 <<< FRAC;
        a[0] = d.a_x; a[1] = d.a_y; a[2] = d.a_z; a[3] = d.a_w;
        b[0] = d.b_x; b[1] = d.b_y; b[2] = d.b_z; b[3] = d.b_w;
        dot = 0;
        for (int k = 0; k < 4; k++) dot += a[k] * b[k];
        t = d.weight;
        if (t > 65536) t = 65536;
        if (dot < 0) begin
            dot = -dot;
            for (int k = 0; k < 4; k++) a[k] = -a[k];
        end
        lin = dot >= ((32768 - longint'(thr)) <<< 15);
        if (!lin) begin
            dq = (dot + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
            if (dq > one) dq = one;
            s = int_sqrt(one * one - dq * dq);
            theta = vector_angle(dq, s);
            if (theta < 0) theta = 0;
            phi1 = (t * theta + 32768) >>> 16;
            phi0 = theta - phi1;
            sth = rotate_sine(theta);
            if (sth <= 0) begin
                lin = 1'b1;
            end else begin
                w0 = blend_weight(rotate_sine(phi0), sth);
                w1 = blend_weight(rotate_sine(phi1), sth);
                for (int k = 0; k < 4; k++)
                    r[k] = clip16((w0 * a[k] + w1 * b[k] + (one >>> 1)) >>> FRAC);
            end
        end
        if (lin) begin
            for (int k = 0; k < 4; k++)
                r[k] = clip16(((65536 - t) * a[k] + t * b[k] + 32768) >>> 16);
        end
        o.out_x = r[0]; o.out_y = r[1]; o.out_z = r[2]; o.out_w = r[3];
        o.used_linear = lin;
        return o;
    endfunction

    class slerp_scoreboard;
        out_beat_t pending[$];
        logic [14:0] margin;
        int errors;

        function new();
            margin = THR_RESET;
            errors = 0;
        endfunction

        function void note_input(in_beat_t d);
            pending.push_back(slerp_result(d, margin));
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing pending: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_x !== e.out_x) begin
                $error("out_x expected %0d actual %0d", e.out_x, got.out_x); errors++;
            end
            if (got.out_y !== e.out_y) begin
                $error("out_y expected %0d actual %0d", e.out_y, got.out_y); errors++;
            end
            if (got.out_z !== e.out_z) begin
                $error("out_z expected %0d actual %0d", e.out_z, got.out_z); errors++;
            end
            if (got.out_w !== e.out_w) begin
                $error("out_w expected %0d actual %0d", e.out_w, got.out_w); errors++;
            end
            if (got.used_linear !== e.used_linear) begin
                $error("used_linear expected %0d actual %0d", e.used_linear,
                       got.used_linear);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    in_beat_t s_data;
    out_beat_t m_data;
    logic cfg_wr_en;
    logic [14:0] cfg_wr_data;
    longint cycles;
    bit long_hold;
    slerp_scoreboard sb;

    quaternion_slerp_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[quaternion_slerp_unit] ERROR");
                $finish;
            end
        end
    end

    // sample beats at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // receiver: random stall pattern, plus one long hold-off on request
    initial begin
        int hold;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                for (hold = 0; hold < 4 * LATENCY; hold++) @(negedge aclk);
                long_hold = 0;
                m_ready <= 1'b1;
            end else if (cycles % 700 < 150) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic send_beat(in_beat_t d);
        s_data  <= d;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    task automatic drain_and_write(logic [14:0] thr);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.margin = thr;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return -16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return ONE_T;
            2: return 17'h1ffff;
            3: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // random pair: unit-ish, b near a (small angles and the lerp region), or fully random
    function automatic in_beat_t rand_beat();
        in_beat_t d;
        int mode;
        mode = $urandom_range(0, 3);
        d.a_x = rand_comp(); d.a_y = rand_comp(); d.a_z = rand_comp();
        d.a_w = rand_comp();
        d.b_x = rand_comp(); d.b_y = rand_comp(); d.b_z = rand_comp();
        d.b_w = rand_comp();
        if (mode == 0) begin
            // unit-ish pair: one large component each, sign of b random
            d.a_x = 16'($urandom_range(0, 16383) - 8192); d.a_y = 16'sd0;
            d.a_z = 16'sd0; d.a_w = 16'($urandom_range(24000, 32767));
            d.b_x = 16'($urandom_range(0, 16383) - 8192); d.b_y = 16'sd0;
            d.b_z = 16'sd0;
            d.b_w = $urandom_range(0, 1) ? 16'($urandom_range(24000, 32767))
                                         : 16'(-$urandom_range(24000, 32767));
        end else if (mode == 1) begin
            d.b_x = 16'(d.a_x + $urandom_range(0, 15) - 8);
            d.b_y = d.a_y;
            d.b_z = d.a_z;
            d.b_w = d.a_w;
        end
        d.weight = rand_weight();
        return d;
    endfunction

    function automatic in_beat_t make_beat(int ax, int ay, int az, int aw,
                                           int bx, int by, int bz, int bw,
                                           int w);
        in_beat_t d;
        d.a_x = 16'(ax); d.a_y = 16'(ay); d.a_z = 16'(az); d.a_w = 16'(aw);
        d.b_x = 16'(bx); d.b_y = 16'(by); d.b_z = 16'(bz); d.b_w = 16'(bw);
        d.weight = 17'(w);
        return d;
    endfunction

    initial begin
        logic [14:0] thr_set[4];
        sb = new();
        long_hold = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, opposite signs, identical, orthogonal, big weights
        send_beat(make_beat(0, 0, 0, 32767, 0, 0, 0, 32767, 32768));
        send_beat(make_beat(0, 0, 0, 32767, 32767, 0, 0, 0, 32768));
        send_beat(make_beat(0, 0, 0, 32767, 32767, 0, 0, 0, 0));
        send_beat(make_beat(0, 0, 0, 32767, 32767, 0, 0, 0, 65536));
        send_beat(make_beat(0, 0, 0, 32767, 32767, 0, 0, 0, 131071));
        send_beat(make_beat(0, 0, 0, -32768, 0, 0, 0, 32767, 16384));
        send_beat(make_beat(-32768, -32768, -32768, -32768, 32767, 32767, 32767,
                            32767, 40000));
        send_beat(make_beat(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, 65536));
        send_beat(make_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 100000));
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 12345));
        send_beat(make_beat(23170, 0, 0, 23170, 0, 0, 0, 32767, 21845));
        send_beat(make_beat(0, 0, 0, 32767, 4, 0, 0, 32767, 30000));
        send_beat(make_beat(0, 0, 0, 32767, 400, 0, 0, -32767, 50000));
        send_beat(make_beat(16384, -16384, 16384, -16384, 32767, 0, 0, 0, 1));
        send_beat(make_beat(0, 0, 0, 32767, -32768, 0, 0, 0, 65535));
        send_beat(make_beat(-1, 1, -1, 1, 1, -1, 1, -1, 32768));

        thr_set[0] = THR_MAX;
        thr_set[1] = THR_MIN;
        thr_set[2] = 15'd1000;
        thr_set[3] = THR_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            int n;
            if (ph > 0) drain_and_write(thr_set[ph - 1]);
            n = 0;
            while (n < NUM_RANDOM / 5) begin
                int burst;
                burst = $urandom_range(1, 40);
                for (int j = 0; j < burst && n < NUM_RANDOM / 5; j++) begin
                    if (ph == 2 && n == 100) long_hold = 1;
                    send_beat(rand_beat());
                    n++;
                end
                if ($urandom_range(0, 2) == 0) send_gap();
            end
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("[quaternion_slerp_unit] OK");
        end else begin
            $display("[quaternion_slerp_unit] ERROR");
        end
        $finish;
    end

endmodule
